// ===== sv/rsi_pkg.sv =====
// rsi_pkg: widths and item types for the ray/sphere intersection pipeline
// no dependencies; imported by ray_sphere_intersect
`default_nettype none

package rsi_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int FRAC_BITS   = 12;

  // derived widths
  localparam int DIFF_W = COORD_WIDTH + 1;        // origin - center
  localparam int PROD_W = 2 * DIFF_W;             // one product term
  localparam int SUM_W  = PROD_W + 2;             // sum of three terms
  localparam int BSH_W  = SUM_W - FRAC_BITS;      // dot product back at FRAC_BITS
  localparam int RAD_W  = COORD_WIDTH - 1;        // unsigned radius
  localparam int RSQ_W  = 2 * RAD_W;              // radius squared
  localparam int DIST_W = 32;                     // b and distance
  localparam int SQ_W   = 2 * DIST_W;             // discriminant
  localparam int ROOT_W = DIST_W;                 // square root steps, one bit each
  localparam int DEXT_W = DIST_W + 2;             // distance before saturation

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [RAD_W-1:0]       radius;
  } query_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DIST_W-1:0] distance;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/ray_sphere_intersect.sv =====
// ray_sphere_intersect: fully pipelined fixed point ray/sphere hit test
// depends on rsi_pkg for the item types and widths
`default_nettype none

// channel   ports                 handshake
// -------   -------------------   -------------------------------------------
// query     start, busy, query    item taken when start high and busy low
// result    done, result          item valid for one cycle while done is high
//
// one item per cycle; after it is taken, each item passes through these stages in order:
// difference, products, sums, b squared, discriminant, one stage per root bit
// (32, restoring square root) and the saturating output register.
// busy never rises, the pipeline has no stall; rst clears only the valid bits.

module ray_sphere_intersect
  import rsi_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     start,
  output logic    busy,
  input  query_t  query,
  output logic    done,
  output result_t result
);

  assign busy = 1'b0;

  // stage 1: differences
  logic                          v1;
  logic signed [DIFF_W-1:0]      dx1, dy1, dz1;
  logic signed [COORD_WIDTH-1:0] vx1, vy1, vz1;
  logic        [RAD_W-1:0]       r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
    dx1 <= DIFF_W'(query.origin_x) - DIFF_W'(query.center_x);
    dy1 <= DIFF_W'(query.origin_y) - DIFF_W'(query.center_y);
    dz1 <= DIFF_W'(query.origin_z) - DIFF_W'(query.center_z);
    vx1 <= query.dir_x;
    vy1 <= query.dir_y;
    vz1 <= query.dir_z;
    r1  <= query.radius;
  end

  // stage 2: products
  logic                     v2;
  logic signed [PROD_W-1:0] px2, py2, pz2, sx2, sy2, sz2;
  logic        [RSQ_W-1:0]  rr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    px2 <= dx1 * vx1;
    py2 <= dy1 * vy1;
    pz2 <= dz1 * vz1;
    sx2 <= dx1 * dx1;
    sy2 <= dy1 * dy1;
    sz2 <= dz1 * dz1;
    rr2 <= r1 * r1;
  end

  // stage 3: b = floor(dot / 2^FRAC_BITS) saturated, c = |dst|^2 - r^2
  logic signed [SUM_W-1:0]  bw;
  logic signed [BSH_W-1:0]  bsh;
  logic signed [DIST_W-1:0] b_sat;
  logic                     v3;
  logic signed [DIST_W-1:0] b3;
  logic signed [SUM_W-1:0]  c3;

  always_comb begin
    bw  = SUM_W'(px2) + SUM_W'(py2) + SUM_W'(pz2);
    bsh = BSH_W'(bw >>> FRAC_BITS);
    // out of range when the bits above the sign are not all equal
    if ((&bsh[BSH_W-1:DIST_W-1]) || !(|bsh[BSH_W-1:DIST_W-1])) begin
      b_sat = bsh[DIST_W-1:0];
    end else if (bsh[BSH_W-1]) begin
      b_sat = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      b_sat = {1'b0, {(DIST_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    b3 <= b_sat;
    c3 <= SUM_W'(sx2) + SUM_W'(sy2) + SUM_W'(sz2) - SUM_W'($signed({1'b0, rr2}));
  end

  // stage 4: b squared
  logic                     v4;
  logic signed [SQ_W-1:0]   bsq4;
  logic signed [DIST_W-1:0] b4;
  logic signed [SUM_W-1:0]  c4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    bsq4 <= b3 * b3;
    b4   <= b3;
    c4   <= c3;
  end

  // stage 5: discriminant and hit decision; tangent counts as miss
  logic signed [SQ_W-1:0] d_disc;

  assign d_disc = bsq4 - SQ_W'(c4);

  logic                     vr  [0:ROOT_W];
  logic                     hr  [0:ROOT_W];
  logic signed [DIST_W-1:0] br  [0:ROOT_W];
  logic        [SQ_W-1:0]   rem [0:ROOT_W-1];
  logic        [SQ_W-1:0]   res [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else begin
      vr[0] <= v4;
    end
    hr[0]  <= ~d_disc[SQ_W-1] & (|d_disc);
    br[0]  <= b4;
    rem[0] <= (~d_disc[SQ_W-1] & (|d_disc)) ? d_disc : '0;
    res[0] <= '0;
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SQ_W-1:0] trial;
    logic            take;

    assign trial = res[k] + STEP_BIT;
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k+1] <= 1'b0;
      end else begin
        vr[k+1] <= vr[k];
      end
      hr[k+1]  <= hr[k];
      br[k+1]  <= br[k];
      res[k+1] <= take ? ((res[k] >> 1) + STEP_BIT) : (res[k] >> 1);
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[k+1] <= take ? (rem[k] - trial) : rem[k];
      end
    end
  end

  // output: distance = -b - root, saturated
  logic        [DIST_W-1:0] root;
  logic signed [DEXT_W-1:0] dext;
  logic signed [DIST_W-1:0] dist_sat;

  always_comb begin
    root = res[ROOT_W][DIST_W-1:0];
    dext = -DEXT_W'(br[ROOT_W]) - DEXT_W'($signed({1'b0, root}));
    if ((&dext[DEXT_W-1:DIST_W-1]) || !(|dext[DEXT_W-1:DIST_W-1])) begin
      dist_sat = dext[DIST_W-1:0];
    end else if (dext[DEXT_W-1]) begin
      dist_sat = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      dist_sat = {1'b0, {(DIST_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vr[ROOT_W];
    end
    result.hit      <= hr[ROOT_W];
    result.distance <= hr[ROOT_W] ? dist_sat : '0;
  end

endmodule

`default_nettype wire
